/* sv/channel_histogram_median_baseline_macros.svh */
// Assertion macros shared by the histogram median checker.
`ifndef CHANNEL_HISTOGRAM_MEDIAN_BASELINE_MACROS_SVH
`define CHANNEL_HISTOGRAM_MEDIAN_BASELINE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CHMB_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CHMB_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/chmb_pkg.sv */
// Shared constants, command codes and controller/datapath interface types.
package chmb_pkg;

  // Default geometry and count width
  localparam int STATIONS_DEF   = 2;
  localparam int SIDES_DEF      = 2;
  localparam int STRIPS_DEF     = 64;
  localparam int ADC_BINS_DEF   = 4096;
  localparam int COUNT_BITS_DEF = 16;

  // Port field widths
  localparam int CMD_W  = 2;
  localparam int ST_W   = 1;
  localparam int SD_W   = 1;
  localparam int SP_W   = 6;
  localparam int ADC_W  = 12;
  localparam int MED_W  = 12;
  localparam int CNTO_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // transaction taken this cycle
    logic clr;         // clear command taken: drop valid bits, restart sweep
    logic sweep;       // zero one bin entry
    logic add_wr;      // write back sample update
    logic scan_start;  // issue first bin read of a query
    logic scan_step;   // consume one bin, issue the next
    logic emit;        // capture result registers
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic head_done;   // queried channel is empty or out of range
    logic scan_stop;   // median found or last bin reached
    logic sweep_last;  // sweep is at the last entry
  } dp_sts_t;

endpackage

/* sv/chmb_ctrl.sv */
// Controller state machine for the histogram median block.
module chmb_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [chmb_pkg::CMD_W-1:0] cmd_i,
  input  chmb_pkg::dp_sts_t         sts_i,
  output chmb_pkg::dp_cmd_t         ctl_o,
  output logic                      busy_o,
  output logic                      done_o
);
  import chmb_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_ADD,
    S_QHEAD,
    S_QSCAN
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = (state_q == S_IDLE) && start;

  // Commands to the datapath
  always_comb begin
    ctl_o            = '0;
    ctl_o.accept     = accept;
    ctl_o.clr        = accept && (cmd_i == CMD_CLEAR);
    ctl_o.sweep      = (state_q == S_SWEEP);
    ctl_o.add_wr     = (state_q == S_ADD);
    ctl_o.scan_start = (state_q == S_QHEAD) && !sts_i.head_done;
    ctl_o.scan_step  = (state_q == S_QSCAN);
    ctl_o.emit       = ((state_q == S_QHEAD) && sts_i.head_done) ||
                       ((state_q == S_QSCAN) && sts_i.scan_stop);
  end

  // State and registered busy / done strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_SWEEP: begin
          if (sts_i.sweep_last) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            case (cmd_i)
              CMD_CLEAR: begin
                state_q <= S_SWEEP;
                busy_q  <= 1'b1;
              end
              CMD_ADD: begin
                state_q <= S_ADD;
                busy_q  <= 1'b1;
              end
              CMD_QUERY: begin
                state_q <= S_QHEAD;
                busy_q  <= 1'b1;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        S_QHEAD: begin
          if (sts_i.head_done) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_QSCAN;
          end
        end
        S_QSCAN: begin
          if (sts_i.scan_stop) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* sv/chmb_datapath.sv */
// Datapath: bin memory, channel total memory, median scan and result registers.
module chmb_datapath #(
  parameter int STATIONS   = chmb_pkg::STATIONS_DEF,
  parameter int SIDES      = chmb_pkg::SIDES_DEF,
  parameter int STRIPS     = chmb_pkg::STRIPS_DEF,
  parameter int ADC_BINS   = chmb_pkg::ADC_BINS_DEF,
  parameter int COUNT_BITS = chmb_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  chmb_pkg::dp_cmd_t           ctl_i,
  output chmb_pkg::dp_sts_t           sts_o,
  input  logic [chmb_pkg::ST_W-1:0]   station_i,
  input  logic [chmb_pkg::SD_W-1:0]   side_i,
  input  logic [chmb_pkg::SP_W-1:0]   strip_i,
  input  logic [chmb_pkg::ADC_W-1:0]  adc_i,
  output logic [chmb_pkg::MED_W-1:0]  median_adc_o,
  output logic [chmb_pkg::CNTO_W-1:0] sample_count_o,
  output logic                        empty_res_o,
  output logic                        overflowed_o
);
  import chmb_pkg::*;

  localparam int NCH    = STATIONS * SIDES * STRIPS;
  localparam int DEPTH  = NCH * ADC_BINS;
  localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int BIN_W  = $clog2(ADC_BINS);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CB     = COUNT_BITS;
  localparam logic [CB-1:0]     CNT_MAX    = '1;
  localparam logic [BIN_W-1:0]  BIN_LAST   = BIN_W'(ADC_BINS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);

  // Input decode
  logic              ch_ok_in;
  logic [CH_W-1:0]   ch_in;
  logic [BIN_W-1:0]  bin_in;
  logic [ADDR_W-1:0] addr_in;

  always_comb begin
    ch_ok_in = (int'(station_i) < STATIONS) && (int'(side_i) < SIDES) &&
               (int'(strip_i) < STRIPS);
    ch_in    = CH_W'((int'(station_i) * SIDES + int'(side_i)) * STRIPS + int'(strip_i));
    bin_in   = (int'(adc_i) >= ADC_BINS) ? BIN_LAST : BIN_W'(adc_i);
    addr_in  = ADDR_W'(int'(ch_in) * ADC_BINS + int'(bin_in));
  end

  // Latched transaction
  logic              ok_q;
  logic [CH_W-1:0]   ch_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      ok_q   <= ch_ok_in;
      ch_q   <= ch_in;
      addr_q <= addr_in;
    end
  end

  // Channel totals: {overflow, total} memory plus per-channel valid bits
  logic [CB:0]     tot_mem [NCH];
  logic [NCH-1:0]  tot_vld_q;
  logic [CB:0]     tot_rd_q;
  logic            tot_vld_rd_q;
  logic            valid_eff;
  logic [CB-1:0]   total_eff;
  logic            ovf_eff;
  logic            full;
  logic [CB:0]     tot_wr;
  logic            upd_en;

  always_comb begin
    valid_eff = ok_q && tot_vld_rd_q;
    total_eff = valid_eff ? tot_rd_q[CB-1:0] : '0;
    ovf_eff   = valid_eff && tot_rd_q[CB];
    full      = (total_eff == CNT_MAX);
    tot_wr    = full ? {1'b1, total_eff} : {ovf_eff, total_eff + CB'(1)};
    upd_en    = ctl_i.add_wr && ok_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept && ch_ok_in) begin
      tot_rd_q     <= tot_mem[ch_in];
      tot_vld_rd_q <= tot_vld_q[ch_in];
    end
    if (upd_en) begin
      tot_mem[ch_q] <= tot_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_vld_q <= '0;
    end else if (ctl_i.clr) begin
      tot_vld_q <= '0;
    end else if (upd_en) begin
      tot_vld_q[ch_q] <= 1'b1;
    end
  end

  // Sweep counter for the bin clearing pass
  logic [ADDR_W-1:0] sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctl_i.clr) begin
      sweep_q <= '0;
    end else if (ctl_i.sweep) begin
      sweep_q <= sweep_q + ADDR_W'(1);
    end
  end

  // Median scan state
  logic [ADDR_W-1:0] scan_addr_q;
  logic [BIN_W-1:0]  idx_q;
  logic [CB-1:0]     run_q;
  logic [CB:0]       sum;
  logic              hit;
  logic              stop;
  logic [CB-1:0]     bin_rd_q;
  logic [ADDR_W-1:0] base;

  always_comb begin
    base = ADDR_W'(int'(ch_q) * ADC_BINS);
    sum  = {1'b0, run_q} + {1'b0, bin_rd_q};
    hit  = {sum, 1'b0} > {2'b00, total_eff};
    stop = hit || (idx_q == BIN_LAST);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_start) begin
      scan_addr_q <= base + ADDR_W'(1);
      idx_q       <= '0;
      run_q       <= '0;
    end else if (ctl_i.scan_step) begin
      scan_addr_q <= scan_addr_q + ADDR_W'(1);
      idx_q       <= idx_q + BIN_W'(1);
      run_q       <= sum[CB-1:0];
    end
  end

  // Bin memory: one write port, one registered read port
  logic [CB-1:0]     bin_mem [DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CB-1:0]     wr_data;
  logic              wr_en;

  always_comb begin
    if (ctl_i.scan_start) begin
      rd_addr = base;
      rd_en   = 1'b1;
    end else if (ctl_i.scan_step) begin
      rd_addr = scan_addr_q;
      rd_en   = !stop;
    end else begin
      rd_addr = addr_in;
      rd_en   = ctl_i.accept && ch_ok_in;
    end
    if (ctl_i.sweep) begin
      wr_addr = sweep_q;
      wr_data = '0;
      wr_en   = 1'b1;
    end else begin
      wr_addr = addr_q;
      wr_data = bin_rd_q + CB'(1);
      wr_en   = upd_en && !full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      bin_rd_q <= bin_mem[rd_addr];
    end
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
  end

  // Result registers
  logic [MED_W-1:0]  med_q;
  logic [CNTO_W-1:0] cnt_q;
  logic              empty_q;
  logic              ovf_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      med_q   <= (ctl_i.scan_step && hit) ? MED_W'(idx_q) : '0;
      cnt_q   <= CNTO_W'(total_eff);
      empty_q <= (total_eff == '0);
      ovf_q   <= ovf_eff;
    end
  end

  assign median_adc_o   = med_q;
  assign sample_count_o = cnt_q;
  assign empty_res_o    = empty_q;
  assign overflowed_o   = ovf_q;

  // Status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.head_done  = (total_eff == '0);
    sts_o.scan_stop  = stop;
    sts_o.sweep_last = (sweep_q == ADDR_LAST);
  end

endmodule

/* sv/channel_histogram_median_baseline.sv */
// Top level of the per-channel ADC histogram with median baseline query.
//
//  channel | handshake      | fields
//  --------+----------------+------------------------------------------------
//  command | start / busy   | cmd_i station_i side_i strip_i adc_i
//  result  | done_o strobe  | median_adc_o sample_count_o empty_res_o overflowed_o
//
// Add: bin and total are read at accept and written back in the ADD state.
// Query: an empty or out-of-range channel is answered from the head state; else the
//   scan reads one bin per cycle from the single bin read port up to the median bin.
// Clear and reset: a pass zeroing the bin memory one entry per cycle, covering
//   all STATIONS*SIDES*STRIPS*ADC_BINS entries (1048576 by default), busy held high.
// done_o is a one-cycle strobe; results cannot be held off by the receiver.
module channel_histogram_median_baseline #(
  parameter int STATIONS   = chmb_pkg::STATIONS_DEF,
  parameter int SIDES      = chmb_pkg::SIDES_DEF,
  parameter int STRIPS     = chmb_pkg::STRIPS_DEF,
  parameter int ADC_BINS   = chmb_pkg::ADC_BINS_DEF,
  parameter int COUNT_BITS = chmb_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [chmb_pkg::CMD_W-1:0]  cmd_i,
  input  logic [chmb_pkg::ST_W-1:0]   station_i,
  input  logic [chmb_pkg::SD_W-1:0]   side_i,
  input  logic [chmb_pkg::SP_W-1:0]   strip_i,
  input  logic [chmb_pkg::ADC_W-1:0]  adc_i,
  output logic                        done_o,
  output logic [chmb_pkg::MED_W-1:0]  median_adc_o,
  output logic [chmb_pkg::CNTO_W-1:0] sample_count_o,
  output logic                        empty_res_o,
  output logic                        overflowed_o
);
  import chmb_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  // Sequencer
  chmb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy),
    .done_o (done_o)
  );

  // Memories and arithmetic
  chmb_datapath #(
    .STATIONS   (STATIONS),
    .SIDES      (SIDES),
    .STRIPS     (STRIPS),
    .ADC_BINS   (ADC_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .station_i      (station_i),
    .side_i         (side_i),
    .strip_i        (strip_i),
    .adc_i          (adc_i),
    .median_adc_o   (median_adc_o),
    .sample_count_o (sample_count_o),
    .empty_res_o    (empty_res_o),
    .overflowed_o   (overflowed_o)
  );

endmodule

/* sv/chmb_checker.sv */
// Port-level checker for the histogram median block, with its bind.
`include "channel_histogram_median_baseline_macros.svh"

module chmb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [chmb_pkg::CMD_W-1:0]  cmd_i,
  input logic                        done_o,
  input logic [chmb_pkg::MED_W-1:0]  median_adc_o,
  input logic [chmb_pkg::CNTO_W-1:0] sample_count_o,
  input logic                        empty_res_o
);
  import chmb_pkg::*;

  // A result ends its transaction: the block is free again
  `CHMB_AST_NOW(a_done_not_busy, done_o, !busy, "result shown while busy")

  // Result strobe is never repeated back to back
  `CHMB_AST_NXT(a_done_single, done_o, !done_o, "result strobe repeated")

  // Empty channel reports zero median and zero count
  `CHMB_AST_NOW(a_empty_zero, done_o && empty_res_o, (median_adc_o == 12'd0) && (sample_count_o == 16'd0), "empty result with data")

  // A query holds the block busy and gives no result in the next cycle
  `CHMB_AST_NXT(a_query_busy, start && !busy && (cmd_i == CMD_QUERY), busy && !done_o, "query not held busy")

  // Only a query produces a result
  `CHMB_AST_NXT(a_no_result, start && !busy && (cmd_i != CMD_QUERY), !done_o, "result without query")

endmodule

bind channel_histogram_median_baseline chmb_checker u_chmb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .done_o         (done_o),
  .median_adc_o   (median_adc_o),
  .sample_count_o (sample_count_o),
  .empty_res_o    (empty_res_o)
);
